[design/wfc_pkg.sv]
// shared types, constants and character classes of the word frequency counter
package wfc_pkg;

    localparam int MAX_WORD_LEN  = 16;
    localparam int TABLE_ENTRIES = 64;
    localparam int COUNT_BITS    = 16;

    localparam int LEN_W   = $clog2(MAX_WORD_LEN + 2);
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int CHARS_W = MAX_WORD_LEN * 8;
    localparam int SLOT_W  = 6;
    localparam int WCNT_W  = 16;
    localparam int Q_DEPTH = 2;

    localparam logic [1:0] ST_COUNTED  = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [WCNT_W-1:0] word_count;
        logic              new_word;
        logic [1:0]        status;
        logic              last;
    } t_out;

    // one closed word handed from front to back
    typedef struct packed {
        logic [CHARS_W-1:0] chars;
        logic [LEN_W-1:0]   len;
        logic               emit;
        logic               last;
    } t_job;

    // one table row
    typedef struct packed {
        logic [CHARS_W-1:0]    chars;
        logic [LEN_W-1:0]      len;
        logic [COUNT_BITS-1:0] count;
    } t_row;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13) || (b == CH_NUL);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
               (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return (b == CH_DQUOTE) || (b == CH_SQUOTE) || (b == CH_LPAREN) ||
               (b == CH_RPAREN);
    endfunction

endpackage

[design/wfc_ram.sv]
// generic single write, single read ram with registered read data
module wfc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/wfc_front.sv]
// front end: splits bytes into words, trims them and emits word jobs
module wfc_front import wfc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_in              i_item,
    input  logic [4:0]       i_min_len,
    output logic             o_job_push,
    output t_job             o_job
);
    logic [CHARS_W-1:0] r_chars, n_chars;
    logic [LEN_W-1:0]   r_raw, n_raw, r_kept, n_kept;
    logic               r_lead, n_lead;
    logic [LEN_W-1:0]   nxt_len;
    logic               take, close, emit;

    always_comb begin
        take    = !is_space(i_item.text_byte) && !(r_lead && is_lead(i_item.text_byte));
        close   = is_space(i_item.text_byte) || i_item.end_of_text;
        nxt_len = (r_raw >= LEN_W'(MAX_WORD_LEN + 1)) ? LEN_W'(MAX_WORD_LEN + 1)
                                                       : r_raw + LEN_W'(1);
        n_chars = r_chars;
        n_raw   = r_raw;
        n_kept  = r_kept;
        n_lead  = r_lead;
        if (take) begin
            n_lead = 1'b0;
            for (int j = 0; j < MAX_WORD_LEN; j++) begin
                if (r_raw == LEN_W'(j)) begin
                    n_chars[j*8 +: 8] = i_item.text_byte;
                end
            end
            if (!is_punct(i_item.text_byte)) begin
                n_kept = nxt_len;
            end
            n_raw = nxt_len;
        end
        emit = !n_lead && (n_kept != '0) && ({{(8-LEN_W){1'b0}}, n_kept} >= 8'(i_min_len));
        o_job.chars = n_chars;
        o_job.len   = n_kept;
        o_job.emit  = emit;
        o_job.last  = i_item.end_of_text;
        o_job_push  = i_accept && close && (emit || i_item.end_of_text);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw  <= '0;
            r_kept <= '0;
            r_lead <= 1'b1;
        end else if (i_accept) begin
            if (close) begin
                r_raw  <= '0;
                r_kept <= '0;
                r_lead <= 1'b1;
            end else begin
                r_raw  <= n_raw;
                r_kept <= n_kept;
                r_lead <= n_lead;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_chars <= n_chars;
        end
    end
endmodule

[design/wfc_queue.sv]
// two entry job queue between front and back
module wfc_queue import wfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);
    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_job          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

[design/wfc_back.sv]
// back end: searches the table for each word job and updates it
module wfc_back import wfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_out o_result
);
    typedef enum logic [1:0] {S_IDLE, S_RD, S_CMP, S_RES} t_state;

    t_state            r_state;
    t_job              r_job;
    logic [USED_W-1:0] r_i, r_used;
    t_out              r_res, r_out;
    logic              r_ov, n_ov;

    logic              we, re;
    logic [IDX_W-1:0]  waddr;
    t_row              wrow, rrow;
    logic              hit, cmp_hit, scan_end;
    logic              job_long;
    logic [COUNT_BITS-1:0] inc;
    logic              out_free;

    wfc_ram #(.W($bits(t_row)), .D(TABLE_ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wrow),
        .i_re    (re),
        .i_raddr (r_i[IDX_W-1:0]),
        .o_rdata (rrow)
    );

    always_comb begin
        hit = (rrow.len == r_job.len);
        for (int j = 0; j < MAX_WORD_LEN; j++) begin
            if ((LEN_W'(j) < r_job.len) && (rrow.chars[j*8 +: 8] != r_job.chars[j*8 +: 8])) begin
                hit = 1'b0;
            end
        end
        // empty-table marker means no row was read, so never a hit
        cmp_hit  = (r_i != USED_W'(TABLE_ENTRIES)) && hit;
        scan_end = (r_i == USED_W'(TABLE_ENTRIES)) || (r_i + USED_W'(1) == r_used);
        job_long = (i_job.len > LEN_W'(MAX_WORD_LEN));
        inc      = (rrow.count == {COUNT_BITS{1'b1}}) ? rrow.count
                                                      : rrow.count + COUNT_BITS'(1);
        re       = (r_state == S_RD);
        out_free = !r_ov || i_pop;
        n_ov     = (r_state == S_RES && out_free) ? 1'b1 : (r_ov && !i_pop);
        o_job_pop = (r_state == S_IDLE) && i_job_valid;
        we    = 1'b0;
        waddr = r_used[IDX_W-1:0];
        wrow.chars = r_job.chars;
        wrow.len   = r_job.len;
        wrow.count = COUNT_BITS'(1);
        if (r_state == S_CMP && cmp_hit) begin
            we         = 1'b1;
            waddr      = r_i[IDX_W-1:0];
            wrow.count = inc;
        end else if (r_state == S_CMP && scan_end &&
                     (r_used != USED_W'(TABLE_ENTRIES))) begin
            we = 1'b1;
        end
    end

    assign o_empty  = !r_ov;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= n_ov;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_res <= '{slot: SLOT_W'(0), word_count: WCNT_W'(0), new_word: 1'b0,
                                   status: (i_job.emit && job_long) ? ST_TOO_LONG : ST_COUNTED,
                                   last: i_job.last};
                        if (!i_job.emit) begin
                            r_i <= '0;
                            if (i_job.last) begin
                                r_used <= '0;
                            end
                        end else if (job_long) begin
                            r_i     <= '0;
                            r_state <= S_RES;
                            if (i_job.last) begin
                                r_used <= '0;
                            end
                        end else if (r_used == '0) begin
                            // empty table: direct append at entry zero
                            r_state <= S_CMP;
                            r_i     <= USED_W'(TABLE_ENTRIES);
                        end else begin
                            r_i     <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (cmp_hit) begin
                        r_res.slot       <= SLOT_W'(r_i[IDX_W-1:0]);
                        r_res.word_count <= WCNT_W'(inc);
                        r_state          <= S_RES;
                        if (r_job.last) begin
                            r_used <= '0;
                        end
                    end else if (scan_end) begin
                        r_state <= S_RES;
                        if (r_used == USED_W'(TABLE_ENTRIES)) begin
                            r_res.status <= ST_FULL;
                        end else begin
                            r_res.slot       <= SLOT_W'(r_used[IDX_W-1:0]);
                            r_res.word_count <= WCNT_W'(1);
                            r_res.new_word   <= 1'b1;
                        end
                        if (r_job.last) begin
                            r_used <= '0;
                        end else if (r_used != USED_W'(TABLE_ENTRIES)) begin
                            r_used <= r_used + USED_W'(1);
                        end
                    end else begin
                        r_i     <= r_i + USED_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[design/word_frequency_counter.sv]
// top level of the word frequency counter: front, job queue, table back end
//
// channel   direction  handshake            beat
// input     in         i_push / o_full      one text byte plus end-of-text flag
// result    out        o_empty / i_pop      one counted or dropped word
// config    in         i_cfg_valid/ready    min_word_length (5 bits)
//
// a byte is taken every cycle while the job queue has room; the front
// waits on the table search only when the job queue is full
// each closed word within the length limit costs the back end one ram read and one
// compare per table entry searched (S_RD, S_CMP), plus S_IDLE to start and S_RES to hand off
// synchronous active-low reset; the table needs no clearing pass since
// only entries below the used count are ever read
// a pending result waits in the output register while new bytes stream in
module word_frequency_counter import wfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  t_in        i_item,
    output logic       o_empty,
    input  logic       i_pop,
    output t_out       o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data
);
    logic [4:0] r_min_len;
    logic       accept;
    logic       job_push, job_pop, job_valid, q_full;
    t_job       job_in, job_out;

    // config register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= 5'd4;
        end else if (i_cfg_valid) begin
            r_min_len <= i_cfg_data;
        end
    end

    // stall input whenever the queue cannot take a word
    assign o_full = q_full;
    assign accept = i_push && !q_full;

    wfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_min_len  (r_min_len),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    wfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (q_full),
        .o_valid (job_valid),
        .o_job   (job_out)
    );

    wfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (o_result)
    );
endmodule

[bench/word_frequency_counter_test.sv]
// testbench for the word frequency counter: directed texts, random texts, result checking
module word_frequency_counter_test;
    import wfc_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int SETTLE_CYC  = 200;     // worst table search plus hand-off
    localparam int CYCLE_LIMIT = 600000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic       o_full;
    t_in        i_item = '0;
    logic       o_empty;
    logic       i_pop = 1'b0;
    t_out       o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [4:0] i_cfg_data = '0;

    word_frequency_counter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full), .i_item(i_item),
        .o_empty(o_empty), .i_pop(i_pop), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // word counting model: own copy of pending word, table and threshold
    // ---------------------------------------------------------------
    logic [7:0] pend_chars [MAX_WORD_LEN];
    int         pend_raw, pend_kept;
    bit         in_lead = 1'b1;
    logic [7:0] dict_chars [TABLE_ENTRIES][MAX_WORD_LEN];
    int         dict_len   [TABLE_ENTRIES];
    int         dict_count [TABLE_ENTRIES];
    int         dict_used;
    int         min_len = 4;

    t_out       expected_words [$];
    int         errors;
    int         cycles;
    bit         calm;              // when set, no gaps on the input side and no stalls on pop
    int         pop_hold;

    function automatic bit char_sep(logic [7:0] b);
        return b == 8'd32 || (b >= 8'd9 && b <= 8'd13) || b == 8'd0;
    endfunction

    function automatic bit char_punct(logic [7:0] b);
        return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
               (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
    endfunction

    function automatic bit char_lead_drop(logic [7:0] b);
        return b == CH_DQUOTE || b == CH_SQUOTE || b == CH_LPAREN || b == CH_RPAREN;
    endfunction

    // closes the pending word and queues its result if one is due
    task automatic close_word(bit last_flag);
        t_out r;
        bit   hit;
        r = '0;
        r.last = last_flag;
        if (pend_kept == 0 || pend_kept < min_len) return;
        if (pend_kept > MAX_WORD_LEN) begin
            r.status = ST_TOO_LONG;
        end else begin
            hit = 1'b0;
            for (int i = 0; i < dict_used && !hit; i++) begin
                if (dict_len[i] == pend_kept) begin
                    hit = 1'b1;
                    for (int k = 0; k < pend_kept; k++)
                        if (dict_chars[i][k] != pend_chars[k]) hit = 1'b0;
                    if (hit) begin
                        if (dict_count[i] < (1 << COUNT_BITS) - 1) dict_count[i]++;
                        r.slot = SLOT_W'(i);
                        r.word_count = WCNT_W'(dict_count[i]);
                    end
                end
            end
            if (!hit) begin
                if (dict_used >= TABLE_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    for (int k = 0; k < pend_kept; k++) dict_chars[dict_used][k] = pend_chars[k];
                    dict_len[dict_used] = pend_kept;
                    dict_count[dict_used] = 1;
                    r.slot = SLOT_W'(dict_used);
                    r.word_count = WCNT_W'(1);
                    r.new_word = 1'b1;
                    dict_used++;
                end
            end
        end
        expected_words.push_back(r);
    endtask

    task automatic count_byte(t_in it);
        bit sep;
        int pos;
        sep = char_sep(it.text_byte);
        if (!sep && !(in_lead && char_lead_drop(it.text_byte))) begin
            pos = pend_raw;
            in_lead = 1'b0;
            if (pos < MAX_WORD_LEN) pend_chars[pos] = it.text_byte;
            if (!char_punct(it.text_byte))
                pend_kept = (pos + 1 > MAX_WORD_LEN + 1) ? MAX_WORD_LEN + 1 : pos + 1;
            pend_raw = (pos + 1 > MAX_WORD_LEN + 1) ? MAX_WORD_LEN + 1 : pos + 1;
        end
        if (sep || it.end_of_text) begin
            if (!in_lead) close_word(it.end_of_text);
            pend_raw = 0;
            pend_kept = 0;
            in_lead = 1'b1;
        end
        if (it.end_of_text) dict_used = 0;
    endtask

    // ---------------------------------------------------------------
    // idling: mostly short gaps, now and then a long one
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sends one beat and feeds the model once it is taken
    task automatic send_byte(logic [7:0] b, bit eot);
        int gap;
        t_in it;
        it.text_byte = b;
        it.end_of_text = eot;
        i_push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_full);
        count_byte(it);
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(string s, bit eot_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_last && i == s.len() - 1);
    endtask

    // threshold write, only with the block drained and quiet
    task automatic set_min_len(int v);
        i_push <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v[4:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        min_len = v;
    endtask

    // ---------------------------------------------------------------
    // result side: random stalls on pop, check every accepted beat
    // ---------------------------------------------------------------
    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_words.size() == 0) begin
                report("unexpected result slot", o_result.slot, -1);
            end else begin
                want = expected_words.pop_front();
                if (o_result.slot != want.slot) report("slot", o_result.slot, want.slot);
                if (o_result.word_count != want.word_count)
                    report("word_count", o_result.word_count, want.word_count);
                if (o_result.new_word != want.new_word)
                    report("new_word", o_result.new_word, want.new_word);
                if (o_result.status != want.status)
                    report("status", o_result.status, want.status);
                if (o_result.last != want.last) report("last", o_result.last, want.last);
            end
        end
        if (pop_hold > 0) begin
            i_pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else begin
            i_pop <= 1'b1;
            if (!calm) pop_hold <= pick_gap();
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // directed tests
    // ---------------------------------------------------------------

    // every separator, high bytes as letters, repeats of one word
    task automatic test_separators();
        send_text("word word\tword\nword\013word\014word\rword", 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd255, 1'b0);
        send_byte(8'd128, 1'b0);
        send_byte(8'd200, 1'b0);
        send_text("\377\200\310 ", 1'b1);
    endtask

    // leading quotes and brackets dropped, trailing punctuation trimmed
    task automatic test_trim();
        send_text("\"('word') word!!, (\"\") ... 'x'y' abc;d: ,,,,", 1'b1);
    endtask

    // words over the length limit, exactly at it, and cut by end of text
    task automatic test_long_words();
        send_text("abcdefghijklmnop abcdefghijklmnopq abcdefghijklmnopqrstuvwxyz ", 1'b0);
        send_text("abcdefghijklmnop!!!! abcdefghijklmnop", 1'b1);
    endtask

    // threshold extremes: zero still ignores empty words, 16 keeps only full length
    task automatic test_thresholds();
        set_min_len(0);
        send_text("a a b !! '' c", 1'b1);
        set_min_len(16);
        send_text("abcdefghijklmno abcdefghijklmnop abcdefghijklmnop", 1'b1);
        set_min_len(1);
    endtask

    // fill the table, then one new word too many and a repeat that still hits
    task automatic test_table_full();
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            send_byte(8'(65 + i / 16), 1'b0);
            send_byte(8'(97 + i % 16), 1'b0);
            send_byte(8'd32, 1'b0);
        end
        send_text("Aa", 1'b1);
        send_text(" ", 1'b1);
    endtask

    // random texts: mostly well formed words from a small vocabulary, some noise
    task automatic test_random_texts();
        string vocab [24];
        string lead_set;
        string tail_set;
        string sep_set;
        int    sent;
        int    n;
        int    pick;
        byte   c;
        lead_set = "\"(')";
        tail_set = ".,!?;:)'";
        sep_set  = " \t\n\r\013\014";
        for (int v = 0; v < 24; v++) begin
            vocab[v] = "";
            n = (v < 3) ? $urandom_range(17, 20) : $urandom_range(1, 8);
            for (int k = 0; k < n; k++) begin
                c = ($urandom_range(0, 3) == 0) ? byte'($urandom_range(65, 90))
                                                : byte'($urandom_range(97, 102));
                vocab[v] = {vocab[v], string'(c)};
            end
        end
        sent = 0;
        // the directed tests send 445 bytes before this
        while (sent < 290) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0: set_min_len(0);
                    1: set_min_len(16);
                    default: set_min_len($urandom_range(1, 5));
                endcase
            end
            n = $urandom_range(1, 20);
            for (int w = 0; w < n; w++) begin
                if ($urandom_range(0, 9) < 8) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_byte(lead_set[$urandom_range(0, 3)], 1'b0);
                        sent++;
                    end
                    pick = $urandom_range(0, 23);
                    send_text(vocab[pick], 1'b0);
                    sent += vocab[pick].len();
                    if ($urandom_range(0, 3) == 0) begin
                        send_byte(tail_set[$urandom_range(0, 7)], 1'b0);
                        sent++;
                    end
                    send_byte(sep_set[$urandom_range(0, 5)], 1'b0);
                end else begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                sent++;
            end
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            sent++;
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_separators();
        test_trim();
        test_long_words();
        test_thresholds();
        test_table_full();
        test_random_texts();
        set_min_len(4);
        send_text("last word", 1'b1);
        i_push <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
design/wfc_pkg.sv
design/wfc_ram.sv
design/wfc_front.sv
design/wfc_queue.sv
design/wfc_back.sv
design/word_frequency_counter.sv
bench/word_frequency_counter_test.sv
